/* rtl/core/tig_pkg.sv */
`default_nettype none

package tig_pkg;

	// One in unsigned Q1.16; larger fractions are clamped to it.
	localparam logic [16:0] FRAC_ONE = 17'h10000;

	// Reset value of the inverse resolution register, 10.0 in Q8.8.
	localparam logic [15:0] INV_RES_RESET = 16'd2560;

	// Half an output step of the blended value at scale 2^48.
	localparam logic signed [65:0] VALUE_HALF = 66'sh8000_0000_0000;

	// Half an output step of a gradient product at scale 2^40.
	localparam logic [64:0] GRAD_HALF = 65'h80_0000_0000;

	// Word handed from the blend pipeline to the gradient lanes and the merge stage.
	// All quantities are exact: v0 and dz at scale 2^32, dx and dy at scale 2^32.
	typedef struct packed {
		logic               valid;
		logic signed [47:0] v0;
		logic signed [48:0] dz;
		logic [16:0]        fz;
		logic signed [48:0] dx;
		logic signed [48:0] dy;
	} blend_t;

	// Rounded gradient magnitude and its sign from one gradient lane.
	typedef struct packed {
		logic        neg;
		logic [24:0] mag;
	} grad_part_t;

endpackage

`default_nettype wire

/* rtl/core/tig_blend.sv */
`default_nettype none

module tig_blend (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic signed [15:0] corner_000,
	input  wire logic signed [15:0] corner_001,
	input  wire logic signed [15:0] corner_010,
	input  wire logic signed [15:0] corner_011,
	input  wire logic signed [15:0] corner_100,
	input  wire logic signed [15:0] corner_101,
	input  wire logic signed [15:0] corner_110,
	input  wire logic signed [15:0] corner_111,
	input  wire logic [16:0]        frac_x,
	input  wire logic [16:0]        frac_y,
	input  wire logic [16:0]        frac_z,
	output tig_pkg::blend_t         blend
);

	// Stage 1: clamped fractions, base corners, corner differences along x and their differences along y.
	logic               valid_s1;
	logic [16:0]        fx_s1, fy_s1, fz_s1;
	logic signed [15:0] c000_s1, c001_s1, c010_s1, c011_s1;
	logic signed [16:0] dxa_s1, dxb_s1, dxc_s1, dxd_s1;
	logic signed [17:0] ddx0_s1, ddx1_s1;

	logic signed [16:0] dxa_w, dxb_w, dxc_w, dxd_w;

	assign dxa_w = 17'(corner_100) - 17'(corner_000);
	assign dxb_w = 17'(corner_110) - 17'(corner_010);
	assign dxc_w = 17'(corner_101) - 17'(corner_001);
	assign dxd_w = 17'(corner_111) - 17'(corner_011);

	always_ff @(posedge clk) begin
		if (accept) begin
			fx_s1   <= (frac_x > tig_pkg::FRAC_ONE) ? tig_pkg::FRAC_ONE : frac_x;
			fy_s1   <= (frac_y > tig_pkg::FRAC_ONE) ? tig_pkg::FRAC_ONE : frac_y;
			fz_s1   <= (frac_z > tig_pkg::FRAC_ONE) ? tig_pkg::FRAC_ONE : frac_z;
			c000_s1 <= corner_000;
			c001_s1 <= corner_001;
			c010_s1 <= corner_010;
			c011_s1 <= corner_011;
			dxa_s1  <= dxa_w;
			dxb_s1  <= dxb_w;
			dxc_s1  <= dxc_w;
			dxd_s1  <= dxd_w;
			ddx0_s1 <= 18'(dxb_w) - 18'(dxa_w);
			ddx1_s1 <= 18'(dxd_w) - 18'(dxc_w);
		end
	end

	// Stage 2: blends along x, and the x differences blended along y.
	logic               valid_s2;
	logic [16:0]        fy_s2, fz_s2;
	logic signed [31:0] v00_s2, v01_s2, v10_s2, v11_s2;
	logic signed [32:0] ex0_s2, ex1_s2;

	logic signed [17:0] fx18, fy18_s1;
	logic signed [34:0] p00, p01, p10, p11;
	logic signed [35:0] pe0, pe1;

	assign fx18    = $signed({1'b0, fx_s1});
	assign fy18_s1 = $signed({1'b0, fy_s1});
	assign p00     = fx18 * dxa_s1;
	assign p10     = fx18 * dxb_s1;
	assign p01     = fx18 * dxc_s1;
	assign p11     = fx18 * dxd_s1;
	assign pe0     = fy18_s1 * ddx0_s1;
	assign pe1     = fy18_s1 * ddx1_s1;

	always_ff @(posedge clk) begin
		fy_s2  <= fy_s1;
		fz_s2  <= fz_s1;
		v00_s2 <= 32'(35'($signed({c000_s1, 16'h0000})) + p00);
		v01_s2 <= 32'(35'($signed({c001_s1, 16'h0000})) + p01);
		v10_s2 <= 32'(35'($signed({c010_s1, 16'h0000})) + p10);
		v11_s2 <= 32'(35'($signed({c011_s1, 16'h0000})) + p11);
		ex0_s2 <= 33'(36'($signed({dxa_s1, 16'h0000})) + pe0);
		ex1_s2 <= 33'(36'($signed({dxc_s1, 16'h0000})) + pe1);
	end

	// Stage 3: differences that the y and z blends need.
	logic               valid_s3;
	logic [16:0]        fy_s3, fz_s3;
	logic signed [31:0] v00_s3, v01_s3;
	logic signed [32:0] dv0_s3, dv1_s3;
	logic signed [33:0] ddv_s3;
	logic signed [32:0] ex0_s3;
	logic signed [33:0] dex_s3;

	always_ff @(posedge clk) begin
		fy_s3  <= fy_s2;
		fz_s3  <= fz_s2;
		v00_s3 <= v00_s2;
		v01_s3 <= v01_s2;
		dv0_s3 <= 33'(v10_s2) - 33'(v00_s2);
		dv1_s3 <= 33'(v11_s2) - 33'(v01_s2);
		ddv_s3 <= 34'(v11_s2) - 34'(v01_s2) - 34'(v10_s2) + 34'(v00_s2);
		ex0_s3 <= ex0_s2;
		dex_s3 <= 34'(ex1_s2) - 34'(ex0_s2);
	end

	// Stage 4: blends along y, x and y differences blended along z.
	logic               valid_s4;
	logic [16:0]        fz_s4;
	logic signed [47:0] v0_s4, v1_s4;
	logic signed [48:0] dx_s4, dy_s4;

	logic signed [17:0] fy18_s3, fz18_s3;
	logic signed [50:0] pv0, pv1;
	logic signed [51:0] pdx, pdy;

	assign fy18_s3 = $signed({1'b0, fy_s3});
	assign fz18_s3 = $signed({1'b0, fz_s3});
	assign pv0     = fy18_s3 * dv0_s3;
	assign pv1     = fy18_s3 * dv1_s3;
	assign pdx     = fz18_s3 * dex_s3;
	assign pdy     = fz18_s3 * ddv_s3;

	always_ff @(posedge clk) begin
		fz_s4 <= fz_s3;
		v0_s4 <= 48'(51'($signed({v00_s3, 16'h0000})) + pv0);
		v1_s4 <= 48'(51'($signed({v01_s3, 16'h0000})) + pv1);
		dx_s4 <= 49'(52'($signed({ex0_s3, 16'h0000})) + pdx);
		dy_s4 <= 49'(52'($signed({dv0_s3, 16'h0000})) + pdy);
	end

	// Stage 5: z difference of the y blends, the z gradient itself.
	logic               valid_s5;
	logic [16:0]        fz_s5;
	logic signed [47:0] v0_s5;
	logic signed [48:0] dz_s5, dx_s5, dy_s5;

	always_ff @(posedge clk) begin
		fz_s5 <= fz_s4;
		v0_s5 <= v0_s4;
		dz_s5 <= 49'(v1_s4) - 49'(v0_s4);
		dx_s5 <= dx_s4;
		dy_s5 <= dy_s4;
	end

	// Valid bits travel beside the data words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	assign blend.valid = valid_s5;
	assign blend.v0    = v0_s5;
	assign blend.dz    = dz_s5;
	assign blend.fz    = fz_s5;
	assign blend.dx    = dx_s5;
	assign blend.dy    = dy_s5;

endmodule

`default_nettype wire

/* rtl/core/tig_grad_lane.sv */
`default_nettype none

module tig_grad_lane (
	input  wire logic               clk,
	input  wire logic signed [48:0] diff,
	input  wire logic [15:0]        inv_res,
	output tig_pkg::grad_part_t     part
);

	// Stage 1: split the weighted difference into sign and magnitude.
	logic        neg_s1;
	logic [47:0] mag_s1;

	logic signed [48:0] neg_diff;

	assign neg_diff = 49'sd0 - diff;

	always_ff @(posedge clk) begin
		neg_s1 <= diff[48];
		mag_s1 <= diff[48] ? neg_diff[47:0] : diff[47:0];
	end

	// Stage 2: scale by the inverse resolution as two 24 by 16 partial products.
	logic        neg_s2;
	logic [39:0] pp_lo_s2, pp_hi_s2;

	always_ff @(posedge clk) begin
		neg_s2   <= neg_s1;
		pp_lo_s2 <= mag_s1[23:0] * inv_res;
		pp_hi_s2 <= mag_s1[47:24] * inv_res;
	end

	// Stage 3: combine and round the magnitude to nearest at scale 2^40.
	// The result stays below 2^25, so the 32-bit output never needs clipping.
	logic        neg_s3;
	logic [24:0] mag_s3;

	logic [64:0] sum;

	assign sum = 65'({pp_hi_s2, 24'h000000}) + 65'(pp_lo_s2) + tig_pkg::GRAD_HALF;

	always_ff @(posedge clk) begin
		neg_s3 <= neg_s2;
		mag_s3 <= sum[64:40];
	end

	assign part.neg = neg_s3;
	assign part.mag = mag_s3;

endmodule

`default_nettype wire

/* rtl/core/tig_merge.sv */
`default_nettype none

module tig_merge (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tig_pkg::blend_t    blend,
	input  wire tig_pkg::grad_part_t part_x,
	input  wire tig_pkg::grad_part_t part_y,
	input  wire tig_pkg::grad_part_t part_z,
	output logic                    done,
	output logic signed [15:0]      interp_value,
	output logic signed [31:0]      grad_x,
	output logic signed [31:0]      grad_y,
	output logic signed [31:0]      grad_z
);

	// Stage 6: last blend along z, as two partial products of the z difference.
	logic               valid_s6;
	logic signed [47:0] v0_s6;
	logic signed [42:0] plo_s6, phi_s6;

	logic signed [17:0] fz18;

	assign fz18 = $signed({1'b0, blend.fz});

	always_ff @(posedge clk) begin
		v0_s6  <= blend.v0;
		plo_s6 <= fz18 * $signed({1'b0, blend.dz[23:0]});
		phi_s6 <= fz18 * $signed(blend.dz[48:24]);
	end

	// Stage 7: exact blend at scale 2^48, rounded with halves toward plus infinity.
	logic               valid_s7;
	logic signed [15:0] value_s7;

	logic signed [65:0] vsum;

	assign vsum = 66'($signed({v0_s6, 16'h0000})) + 66'($signed({phi_s6, 24'h000000}))
		+ 66'(plo_s6) + tig_pkg::VALUE_HALF;

	always_ff @(posedge clk) begin
		value_s7 <= vsum[63:48];
	end

	// Stage 8: hold the value while the gradient lanes finish rounding.
	logic               valid_s8;
	logic signed [15:0] value_s8;

	always_ff @(posedge clk) begin
		value_s8 <= value_s7;
	end

	// Output word: restore the gradient signs.
	logic signed [31:0] gx_w, gy_w, gz_w;

	assign gx_w = part_x.neg ? 32'sd0 - 32'($signed({1'b0, part_x.mag}))
		: 32'($signed({1'b0, part_x.mag}));
	assign gy_w = part_y.neg ? 32'sd0 - 32'($signed({1'b0, part_y.mag}))
		: 32'($signed({1'b0, part_y.mag}));
	assign gz_w = part_z.neg ? 32'sd0 - 32'($signed({1'b0, part_z.mag}))
		: 32'($signed({1'b0, part_z.mag}));

	always_ff @(posedge clk) begin
		interp_value <= value_s8;
		grad_x       <= gx_w;
		grad_y       <= gy_w;
		grad_z       <= gz_w;
	end

	// Valid bits and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s6 <= blend.valid;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			done     <= valid_s8;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/trilinear_interp_gradient_top.sv */
// Trilinear interpolation of a distance field inside one voxel cell, with gradient.
// Command channel: drive the eight corner distances and the three fractions and
// raise start; the word is taken at the rising edge where start is high and busy is
// low. busy never rises, so a new word may be issued every clock cycle.
// Result channel: done is high for exactly one cycle while interp_value and
// grad_x, grad_y, grad_z hold the result; the receiver must take it in that cycle.
// Throughput is one word per cycle: every stage is a single register slice.
// The longest stages are the 17 by 34 bit blend multipliers and the 24 by 16 bit
// partial products that scale each gradient by the inverse resolution.
// Configuration: inv_resolution is written through cfg_valid, cfg_ready and
// cfg_data; cfg_ready is always high. Write it only while no word is in flight.
// Reset clears the pipeline valid bits and sets inv_resolution to 10.0 (Q8.8);
// outside reset no word is lost or repeated, and results in flight at reset are dropped.
`default_nettype none

module trilinear_interp_gradient_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [15:0] corner_000,
	input  wire logic signed [15:0] corner_001,
	input  wire logic signed [15:0] corner_010,
	input  wire logic signed [15:0] corner_011,
	input  wire logic signed [15:0] corner_100,
	input  wire logic signed [15:0] corner_101,
	input  wire logic signed [15:0] corner_110,
	input  wire logic signed [15:0] corner_111,
	input  wire logic [16:0]        frac_x,
	input  wire logic [16:0]        frac_y,
	input  wire logic [16:0]        frac_z,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [15:0]        cfg_data,
	output logic                    done,
	output logic signed [15:0]      interp_value,
	output logic signed [31:0]      grad_x,
	output logic signed [31:0]      grad_y,
	output logic signed [31:0]      grad_z
);

	// The pipeline takes a word every cycle.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Inverse resolution register.
	logic [15:0] inv_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_res_q <= tig_pkg::INV_RES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			inv_res_q <= cfg_data;
		end
	end

	// Shared blend pipeline.
	tig_pkg::blend_t blend;

	tig_blend u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (start && !busy),
		.corner_000 (corner_000),
		.corner_001 (corner_001),
		.corner_010 (corner_010),
		.corner_011 (corner_011),
		.corner_100 (corner_100),
		.corner_101 (corner_101),
		.corner_110 (corner_110),
		.corner_111 (corner_111),
		.frac_x     (frac_x),
		.frac_y     (frac_y),
		.frac_z     (frac_z),
		.blend      (blend)
	);

	// One gradient lane per axis.
	tig_pkg::grad_part_t part_x, part_y, part_z;

	tig_grad_lane u_lane_x (
		.clk     (clk),
		.diff    (blend.dx),
		.inv_res (inv_res_q),
		.part    (part_x)
	);

	tig_grad_lane u_lane_y (
		.clk     (clk),
		.diff    (blend.dy),
		.inv_res (inv_res_q),
		.part    (part_y)
	);

	tig_grad_lane u_lane_z (
		.clk     (clk),
		.diff    (blend.dz),
		.inv_res (inv_res_q),
		.part    (part_z)
	);

	// Final value blend and merge of the lane results.
	tig_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.blend        (blend),
		.part_x       (part_x),
		.part_y       (part_y),
		.part_z       (part_z),
		.done         (done),
		.interp_value (interp_value),
		.grad_x       (grad_x),
		.grad_y       (grad_y),
		.grad_z       (grad_z)
	);

endmodule

`default_nettype wire
